// File: rtl/wswd_pkg.sv
// ----------------------------------------------------------------------------
// wswd_pkg
// Shared widths, codes, reset values and types for the wake score window
// detector.
// ----------------------------------------------------------------------------
package wswd_pkg;

    // Field widths
    localparam int SCORE_W    = 8;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 13;
    localparam int WIN_W      = 6;
    localparam int HOLDOFF_W  = 8;
    localparam int COOLDOWN_W = 20;

    // Stream payload widths
    localparam int IN_DATA_W  = 40;  // score + now_ms, already whole bytes
    localparam int IN_USER_W  = 1;   // req_type
    localparam int OUT_DATA_W = 16;  // detected + window_hit + window_sum, padded

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd3;

    // Request kinds carried in tuser
    localparam logic REQ_SCORE   = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Register values after reset
    localparam int RST_CUTOFF   = 128;
    localparam int RST_WINDOW   = 10;
    localparam int RST_HOLDOFF  = 100;
    localparam int RST_COOLDOWN = 2000;

    // Control from the detector to the score ring
    typedef struct packed {
        logic step;    // write the score at the next slot, update the sum
        logic clear;   // empty the ring and zero the sum
        logic rewind;  // put the write slot back to zero
    } t_ring_ctrl;

endpackage

// File: rtl/wake_score_window_detector.sv
// ----------------------------------------------------------------------------
// wake_score_window_detector
// Path: an input transfer is captured in the input register, then passes to
// the result register, which drives m_axis_tvalid.
// Throughput: one item per cycle while m_axis_tready stays high; the
// combinational ring read, running-sum update and threshold compare allow it.
// Reset: synchronous, active low; registers return to their default values,
// the ring empties and the holdoff rearms. No clearing pass is needed.
// Scores go into a ring of the last window_length entries; once the holdoff
// has expired, a window sum above cutoff * window_length raises a hit, which
// is reported as a detection when the cooldown has passed.
// ----------------------------------------------------------------------------
module wake_score_window_detector #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Slave side
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [wswd_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] score, [39:8] now_ms
    input  logic [wswd_pkg::IN_USER_W-1:0]       s_axis_tuser,  // [0] req_type
    // Master side
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [wswd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [0] detected,
                                                                // [1] window_hit,
                                                                // [14:2] window_sum
    // Configuration writes
    input  logic                                 i_cfg_we,
    input  logic [wswd_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [wswd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import wswd_pkg::*;

    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int THR_W      = SCORE_W + LEN_W;
    localparam int CMP_W      = (THR_W > SUM_W) ? THR_W : SUM_W;
    localparam int RST_LEN    = (MAX_WINDOW < RST_WINDOW) ? MAX_WINDOW : RST_WINDOW;
    localparam int RST_THRESH = RST_CUTOFF * RST_LEN;

    // Clamp a window length to 1 .. MAX_WINDOW
    function automatic logic [LEN_W-1:0] clamp_len(input logic [WIN_W-1:0] wl);
        logic [LEN_W-1:0] len;
        if (wl == '0) begin
            len = LEN_W'(1);
        end else if (int'(wl) > MAX_WINDOW) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(wl);
        end
        return len;
    endfunction

    // Configuration
    logic [SCORE_W-1:0]    r_cutoff;
    logic [LEN_W-1:0]      r_eff_len;
    logic [THR_W-1:0]      r_thresh;
    logic [HOLDOFF_W-1:0]  r_holdoff_count;
    logic [COOLDOWN_W-1:0] r_cooldown;

    // Detector state
    logic [HOLDOFF_W-1:0]  r_holdoff_left;
    logic [TIME_W-1:0]     r_last_ms;
    logic                  r_ever;

    // Input register
    logic                  r_in_valid;
    logic                  r_in_req;
    logic [SCORE_W-1:0]    r_in_score;
    logic [TIME_W-1:0]     r_in_now;

    // Result register
    logic                  r_out_valid;
    logic                  r_out_det;
    logic                  r_out_hit;
    logic [SUM_W-1:0]      r_out_sum;

    logic                  advance;
    logic                  is_score;
    logic [HOLDOFF_W-1:0]  n_holdoff_left;
    logic                  expired;
    logic [SUM_W-1:0]      sum_next;
    logic                  hit;
    logic [TIME_W-1:0]     elapsed;
    logic                  cool_ok;
    logic                  det;
    logic                  win_write;
    logic [LEN_W-1:0]      cfg_len;
    t_ring_ctrl            ring_ctrl;

    // Handshake: the result register parts the two sides
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Score ring and running sum
    wswd_ring #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ring_ctrl),
        .i_score    (r_in_score),
        .i_len      (r_eff_len),
        .o_sum_next (sum_next)
    );

    // Evaluate the registered item
    always_comb begin
        is_score = (r_in_req == REQ_SCORE);
        if (is_score && (r_in_score < r_cutoff) && (r_holdoff_left != '0)) begin
            n_holdoff_left = r_holdoff_left - HOLDOFF_W'(1);
        end else begin
            n_holdoff_left = r_holdoff_left;
        end
        expired = (n_holdoff_left == '0);
        hit     = is_score && expired && (CMP_W'(sum_next) > CMP_W'(r_thresh));
        elapsed = r_in_now - r_last_ms;
        cool_ok = !r_ever || (elapsed >= TIME_W'(r_cooldown));
        det     = hit && cool_ok;
    end

    // Ring control
    assign win_write       = i_cfg_we && (i_cfg_addr == CFG_WINDOW);
    assign cfg_len         = clamp_len(i_cfg_wdata[WIN_W-1:0]);
    assign ring_ctrl.step   = advance && is_score;
    assign ring_ctrl.clear  = (advance && (!is_score || hit)) || win_write;
    assign ring_ctrl.rewind = win_write;

    // Configuration registers; the threshold product is formed on the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff        <= SCORE_W'(RST_CUTOFF);
            r_eff_len       <= LEN_W'(RST_LEN);
            r_thresh        <= THR_W'(RST_THRESH);
            r_holdoff_count <= HOLDOFF_W'(RST_HOLDOFF);
            r_cooldown      <= COOLDOWN_W'(RST_COOLDOWN);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CUTOFF: begin
                    r_cutoff <= i_cfg_wdata[SCORE_W-1:0];
                    r_thresh <= THR_W'(i_cfg_wdata[SCORE_W-1:0]) * THR_W'(r_eff_len);
                end
                CFG_WINDOW: begin
                    r_eff_len <= cfg_len;
                    r_thresh  <= THR_W'(r_cutoff) * THR_W'(cfg_len);
                end
                CFG_HOLDOFF: begin
                    r_holdoff_count <= i_cfg_wdata[HOLDOFF_W-1:0];
                end
                CFG_COOLDOWN: begin
                    r_cooldown <= i_cfg_wdata[COOLDOWN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Holdoff and report history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_left <= HOLDOFF_W'(RST_HOLDOFF);
            r_last_ms      <= '0;
            r_ever         <= 1'b0;
        end else if (advance) begin
            if (!is_score || hit) begin
                r_holdoff_left <= r_holdoff_count;
            end else begin
                r_holdoff_left <= n_holdoff_left;
            end
            if (det) begin
                r_last_ms <= r_in_now;
                r_ever    <= 1'b1;
            end
        end
    end

    // Capture input transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req   <= s_axis_tuser[0];
            r_in_score <= s_axis_tdata[SCORE_W-1:0];
            r_in_now   <= s_axis_tdata[SCORE_W +: TIME_W];
        end
    end

    // Hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_det <= det;
            r_out_hit <= hit;
            r_out_sum <= (is_score && expired) ? sum_next : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - SUM_W - 2){1'b0}}, r_out_sum, r_out_hit, r_out_det};

endmodule

// File: rtl/wswd_ring.sv
// ----------------------------------------------------------------------------
// wswd_ring
// Ring of the most recent scores with a running sum. Per-slot valid bits let
// the whole ring clear at once; an empty slot reads as zero.
// ----------------------------------------------------------------------------
module wswd_ring #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wswd_pkg::t_ring_ctrl                  i_ctrl,
    input  logic [wswd_pkg::SCORE_W-1:0]          i_score,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]       i_len,
    output logic [wswd_pkg::SUM_W-1:0]            o_sum_next
);
    import wswd_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [SCORE_W-1:0]    r_ring [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] r_valid;
    logic [IDX_W-1:0]      r_idx;
    logic [SUM_W-1:0]      r_sum;

    logic [IDX_W:0]        idx_inc;
    logic [IDX_W-1:0]      n_idx;
    logic [SCORE_W-1:0]    old_score;
    logic [SUM_W-1:0]      n_sum;

    // Advance the slot, wrap at the window length, swap the oldest score out
    always_comb begin
        idx_inc   = {1'b0, r_idx} + (IDX_W + 1)'(1);
        n_idx     = (idx_inc >= (IDX_W + 1)'(i_len)) ? '0 : idx_inc[IDX_W-1:0];
        old_score = r_valid[n_idx] ? r_ring[n_idx] : '0;
        n_sum     = r_sum - SUM_W'(old_score) + SUM_W'(i_score);
    end

    assign o_sum_next = n_sum;

    // Control state: slot pointer, valid bits, running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= '0;
            r_sum   <= '0;
        end else begin
            if (i_ctrl.rewind) begin
                r_idx <= '0;
            end else if (i_ctrl.step) begin
                r_idx <= n_idx;
            end
            if (i_ctrl.clear) begin
                r_valid <= '0;
                r_sum   <= '0;
            end else if (i_ctrl.step) begin
                r_valid[n_idx] <= 1'b1;
                r_sum          <= n_sum;
            end
        end
    end

    // Score storage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_ring[n_idx] <= i_score;
        end
    end

endmodule
